@@ src/sacl_pkg.sv @@
package sacl_pkg;

  localparam int ADDR_WIDTH       = 32;
  localparam int STAMP_WIDTH      = 32;
  localparam int TOTAL_WIDTH      = 32;
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 5;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WAYS        = 2'd2;

  // access kinds
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [ADDR_WIDTH-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             hit_count;
    logic                   was_miss;
    logic                   was_eviction;
    logic [TOTAL_WIDTH-1:0] total_hits;
    logic [TOTAL_WIDTH-1:0] total_misses;
    logic [TOTAL_WIDTH-1:0] total_evictions;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CMP,
    ST_PICK,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic latch;
    logic look;
    logic cmp;
    logic pick;
    logic upd;
  } dp_cmd_t;

endpackage

@@ src/sacl_ram.sv @@
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sacl_ctrl.sv @@
module sacl_ctrl import sacl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    item_nop,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        state_next = item_nop ? ST_UPD : ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        // hold until the result register is free
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
      end
      ST_UPD: begin
        cmd.upd = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/sacl_dp.sv @@
module sacl_dp import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  in_item_t                   in_data,
  input  dp_cmd_t                    cmd,
  output logic                       item_nop,
  output out_item_t                  out_data
);

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WI_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LEAVES   = 1 << WI_W;
  localparam int WC_W     = $clog2(MAX_WAYS + 1);
  localparam int SH_W     = $clog2(MAX_SET_BITS + 32);
  localparam int LINE_W   = 1 + ADDR_WIDTH + STAMP_WIDTH;
  localparam int ROW_W    = MAX_WAYS * LINE_W;

  function automatic logic [TOTAL_WIDTH-1:0] sat_add(input logic [TOTAL_WIDTH-1:0] v,
                                                     input logic [1:0] inc);
    logic [TOTAL_WIDTH:0] s;
    s = {1'b0, v} + (TOTAL_WIDTH + 1)'(inc);
    return s[TOTAL_WIDTH] ? '1 : s[TOTAL_WIDTH-1:0];
  endfunction

  // configuration
  logic [2:0] set_bits;
  logic [4:0] offset_bits;
  logic [3:0] ways_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 3'd0;
      offset_bits <= 5'd0;
      ways_cfg    <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits    <= cfg_data[2:0];
        CFG_OFFSET_BITS: offset_bits <= cfg_data[4:0];
        CFG_WAYS:        ways_cfg    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // item capture
  logic [1:0]            cmd_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic                  modify;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q  <= in_data.cmd;
      addr_q <= in_data.address;
    end
  end

  assign item_nop = !(cmd_q inside {CMD_LOAD, CMD_STORE, CMD_MODIFY});
  assign modify   = (cmd_q == CMD_MODIFY);

  // address split
  logic [SH_W-1:0]       sb_eff;
  logic [SH_W-1:0]       shift;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_idx;
  logic [ADDR_WIDTH-1:0] tag;
  logic [WC_W-1:0]       ways_eff;
  logic [MAX_WAYS-1:0]   in_use;

  always_comb begin
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb_eff = SH_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SH_W'(set_bits);
    end
    shift   = sb_eff + SH_W'(offset_bits);
    shifted = addr_q >> offset_bits;
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(sb_eff));
    end
    set_idx = shifted[SET_W-1:0] & set_mask;
    tag     = (int'(shift) >= ADDR_WIDTH) ? '0 : (addr_q >> shift);
    if (ways_cfg == 4'd0) begin
      ways_eff = WC_W'(1);
    end else if (int'(ways_cfg) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_cfg);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (w < int'(ways_eff));
    end
  end

  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [MAX_WAYS-1:0]   in_use_q;
  logic                  row_ok_q;
  logic [NUM_SETS-1:0]   row_written;

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      set_q    <= set_idx;
      tag_q    <= tag;
      in_use_q <= in_use;
      row_ok_q <= row_written[set_idx];
    end
  end

  // one row per set holds valid, tag and stamp of every way
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] row_new;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.upd && !item_nop),
    .waddr (set_q),
    .wdata (row_new),
    .re    (cmd.look && !item_nop),
    .raddr (set_idx),
    .rdata (rd_row)
  );

  // compare
  logic [STAMP_WIDTH-1:0] access_clock;
  logic [STAMP_WIDTH-1:0] clock_look;
  logic [MAX_WAYS-1:0]    hit_vec;
  logic [MAX_WAYS-1:0]    free_vec;
  logic [STAMP_WIDTH-1:0] age [MAX_WAYS];

  assign clock_look = access_clock + 1'b1;

  always_comb begin
    logic [LINE_W-1:0] slot;
    logic              v;
    for (int w = 0; w < MAX_WAYS; w++) begin
      slot        = rd_row[w*LINE_W +: LINE_W];
      v           = slot[LINE_W-1] && row_ok_q;
      hit_vec[w]  = v && in_use_q[w] && (slot[LINE_W-2 -: ADDR_WIDTH] == tag_q);
      free_vec[w] = in_use_q[w] && !v;
      age[w]      = in_use_q[w] ? (clock_look - slot[STAMP_WIDTH-1:0]) : '0;
    end
  end

  logic [MAX_WAYS-1:0]    hit_vec_q;
  logic [MAX_WAYS-1:0]    free_vec_q;
  logic [STAMP_WIDTH-1:0] age_q [MAX_WAYS];

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      hit_vec_q  <= hit_vec;
      free_vec_q <= free_vec;
      age_q      <= age;
    end
  end

  // way selection: first hit, else first free, else oldest (ties to lower way)
  logic [WI_W-1:0]        hit_way;
  logic [WI_W-1:0]        free_way;
  logic [STAMP_WIDTH-1:0] tree_age [2*LEAVES-1];
  logic [WI_W-1:0]        tree_way [2*LEAVES-1];

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec_q[w]) hit_way = WI_W'(w);
      if (free_vec_q[w]) free_way = WI_W'(w);
    end
    for (int n = 0; n < 2 * LEAVES - 1; n++) begin
      tree_age[n] = '0;
      tree_way[n] = '0;
    end
    for (int l = 0; l < LEAVES; l++) begin
      tree_way[LEAVES-1+l] = WI_W'(l);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      tree_age[LEAVES-1+w] = age_q[w];
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (tree_age[2*n+2] > tree_age[2*n+1]) begin
        tree_age[n] = tree_age[2*n+2];
        tree_way[n] = tree_way[2*n+2];
      end else begin
        tree_age[n] = tree_age[2*n+1];
        tree_way[n] = tree_way[2*n+1];
      end
    end
  end

  logic [WI_W-1:0] way_q;
  logic            hit_q;
  logic            evict_q;

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      hit_q   <= |hit_vec_q;
      evict_q <= !(|hit_vec_q) && !(|free_vec_q);
      if (|hit_vec_q) begin
        way_q <= hit_way;
      end else if (|free_vec_q) begin
        way_q <= free_way;
      end else begin
        way_q <= tree_way[0];
      end
    end
  end

  // update: a modify's second lookup always hits the same line
  logic [1:0]             n_lookups;
  logic [STAMP_WIDTH-1:0] clock_new;
  logic [1:0]             hit_add;
  logic                   miss_add;
  logic                   evict_add;
  logic [TOTAL_WIDTH-1:0] hit_total;
  logic [TOTAL_WIDTH-1:0] miss_total;
  logic [TOTAL_WIDTH-1:0] eviction_total;
  logic [TOTAL_WIDTH-1:0] hit_total_next;
  logic [TOTAL_WIDTH-1:0] miss_total_next;
  logic [TOTAL_WIDTH-1:0] eviction_total_next;

  always_comb begin
    if (item_nop) begin
      n_lookups = 2'd0;
      hit_add   = 2'd0;
    end else begin
      n_lookups = modify ? 2'd2 : 2'd1;
      hit_add   = {1'b0, hit_q} + {1'b0, modify};
    end
    miss_add            = !item_nop && !hit_q;
    evict_add           = !item_nop && evict_q;
    clock_new           = access_clock + STAMP_WIDTH'(n_lookups);
    hit_total_next      = sat_add(hit_total, hit_add);
    miss_total_next     = sat_add(miss_total, {1'b0, miss_add});
    eviction_total_next = sat_add(eviction_total, {1'b0, evict_add});
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WI_W'(w) == way_q) begin
        row_new[w*LINE_W +: LINE_W] = {1'b1, tag_q, clock_new};
      end else begin
        // a row never written before holds no valid line
        row_new[w*LINE_W +: LINE_W] = {rd_row[w*LINE_W + LINE_W - 1] && row_ok_q,
                                       rd_row[w*LINE_W +: LINE_W - 1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock   <= '0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
      row_written    <= '0;
    end else if (cmd.upd) begin
      access_clock   <= clock_new;
      hit_total      <= hit_total_next;
      miss_total     <= miss_total_next;
      eviction_total <= eviction_total_next;
      if (!item_nop) row_written[set_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_data.hit_count       <= hit_add;
      out_data.was_miss        <= miss_add;
      out_data.was_eviction    <= evict_add;
      out_data.total_hits      <= hit_total_next;
      out_data.total_misses    <= miss_total_next;
      out_data.total_evictions <= eviction_total_next;
    end
  end

endmodule

@@ src/set_assoc_cache_lru_sim.sv @@
// The result is registered after set read, way compare, victim select and
// write-back, in that order; an unused command skips compare and select.
// A new item is taken only once the last one has passed write-back; the
// dependent read-modify-write of one set row bounds the rate. A waiting result does not block
// the next transfer in, but that item holds in write-back until it leaves.
// Reset: synchronous; clears row-written flags, access clock, totals; config to 0 set bits, 0 offset bits, 1 way.
module set_assoc_cache_lru_sim import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_data
);

  dp_cmd_t cmd;
  logic    item_nop;

  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .item_nop  (item_nop),
    .cmd       (cmd)
  );

  sacl_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .item_nop  (item_nop),
    .out_data  (out_data)
  );

endmodule

@@ src/sacl_chk.sv @@
module sacl_chk import sacl_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // one item in flight: ready drops after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // a missed first lookup leaves at most the modify's second hit
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hit_count != 2'd3) &&
                  !(out_data.was_miss && out_data.hit_count[1]))
    else $error("hit count out of range");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.was_eviction) |-> out_data.was_miss)
    else $error("eviction without a miss");

endmodule

bind set_assoc_cache_lru_sim sacl_chk u_sacl_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
